// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL files that check their own behavior.
// Both expect a clock named i_clk in scope; ASSERT_CLKD also expects an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/fpr_pkg.sv =====
package fpr_pkg;

    localparam int WINDOW     = 10;
    localparam int RATE_SCALE = 1000;
    localparam int RATE_NUM   = RATE_SCALE * WINDOW;
    localparam int NUM_W      = $clog2(RATE_NUM + 1);
    localparam int CNT_W      = $clog2(NUM_W);
    localparam int STAMP_W    = 32;
    localparam int IVL_W      = 16;
    localparam int RATE_W     = 14;
    localparam int OUT_W      = 16;

    localparam logic [RATE_W-1:0] RATE_MAX  = {RATE_W{1'b1}};
    localparam logic [IVL_W-1:0]  IVL_RESET = 16'd16;

    typedef enum logic {
        OP_START = 1'b0,
        OP_CHECK = 1'b1
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic fill;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] rate;
    } t_div_res;

    // Clamp a raw quotient to the largest value the rate field can hold.
    function automatic logic [RATE_W-1:0] sat_rate(input logic [NUM_W-1:0] q);
        logic [31:0] q_ext;
        q_ext = 32'(q);
        if (q_ext > 32'(RATE_MAX)) begin
            return RATE_MAX;
        end
        return RATE_W'(q);
    endfunction

endpackage

// ===== rtl/fpr_cell.sv =====
module fpr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fpr_pkg::t_cell_ctrl         i_ctrl,
    input  logic [fpr_pkg::STAMP_W-1:0] i_fill_data,
    input  logic [fpr_pkg::STAMP_W-1:0] i_next_data,
    output logic [fpr_pkg::STAMP_W-1:0] o_stamp
);
    import fpr_pkg::*;

    logic [STAMP_W-1:0] r_stamp;
    logic [STAMP_W-1:0] n_stamp;

    // A start fills the cell; an accepted frame takes the newer neighbor's stamp.
    always_comb begin
        n_stamp = r_stamp;
        if (i_ctrl.fill) begin
            n_stamp = i_fill_data;
        end else if (i_ctrl.shift) begin
            n_stamp = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
        end else begin
            r_stamp <= n_stamp;
        end
    end

    assign o_stamp = r_stamp;

endmodule

// ===== rtl/fpr_div.sv =====
module fpr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fpr_pkg::STAMP_W-1:0] i_divisor,
    output fpr_pkg::t_div_res           o_res
);
    import fpr_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [STAMP_W-1:0] r_rem, n_rem;
    logic [STAMP_W-1:0] r_dvs, n_dvs;
    logic [NUM_W-1:0]   r_quot, n_quot;

    logic [STAMP_W:0]   w_trial;
    logic [STAMP_W:0]   w_diff;
    logic               w_ge;

    // Restoring division, one quotient bit per cycle. The dividend sits in the
    // quotient register and is shifted out at the top as quotient bits come in.
    assign w_trial = {r_rem, r_quot[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quot = NUM_W'(RATE_NUM);
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[STAMP_W-1:0] : w_trial[STAMP_W-1:0];
            n_quot = {r_quot[NUM_W-2:0], w_ge};
            n_cnt  = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    assign o_res.done = r_done;
    assign o_res.rate = sat_rate(r_quot);

endmodule

// ===== rtl/frame_pacer_rate_meter.sv =====
// Frame pacer and rate meter. Each request carries a millisecond time stamp and
// an opcode. A start request fills the timestamp window with its time, clears the
// newest slot and answers at once with the current rate. A check request compares
// the time since the newest stamp with the configured frame interval; if it is
// too short the answer is wait, otherwise the window moves up by one slot, the
// rate becomes 1000*WINDOW over the span back to the oldest stamp, and the new
// time becomes the newest stamp. Start requests, wait answers and accepted frames
// whose span back to the oldest stamp is zero produce their result in the cycle
// after acceptance. Any other accepted frame runs a bit-serial divider that
// produces one quotient bit per cycle, and its result is registered once the
// divider reports that it is done.
// The block holds one request at a time; the next is taken once the divider is
// idle and the previous result has been taken or is being taken.
module frame_pacer_rate_meter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Frame interval register write.
    input  logic                        i_cfg_we,
    input  logic [fpr_pkg::IVL_W-1:0]   i_cfg_wdata,
    // Request channel.
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [fpr_pkg::STAMP_W-1:0] i_s_tdata,   // [31:0] now_ms
    input  logic                        i_s_tuser,   // [0] opcode
    // Result channel.
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [fpr_pkg::OUT_W-1:0]   o_m_tdata    // [0] wait_res, [14:1] frame_rate
);
    import fpr_pkg::*;

    `include "assert_macros.svh"

    t_state            r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              r_out_wait, n_out_wait;
    logic [RATE_W-1:0] r_out_rate, n_out_rate;
    logic [RATE_W-1:0] r_rate, n_rate;
    logic [IVL_W-1:0]  r_interval;

    logic [STAMP_W-1:0] w_stamp [WINDOW];
    t_cell_ctrl         w_ctrl;
    t_div_res           w_div;
    logic               w_div_start;
    logic               w_in_fire;
    logic               w_out_fire;
    logic [STAMP_W-1:0] w_since;
    logic [STAMP_W-1:0] w_span;
    t_op                w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= IVL_RESET;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_wdata;
        end
    end

    // The window is a row of cells, oldest at index zero. On an accepted frame every
    // cell but the newest takes the stamp of its newer neighbor and the newest cell
    // takes the request time. A start loads the request time into all but the newest, which it clears.
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_cell
            fpr_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_fill_data ((gi == WINDOW - 1) ? '0 : i_s_tdata),
                .i_next_data ((gi == WINDOW - 1) ? i_s_tdata : w_stamp[(gi + 1) % WINDOW]),
                .o_stamp     (w_stamp[gi])
            );
        end
    endgenerate

    fpr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (w_span),
        .o_res     (w_div)
    );

    assign o_s_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);
    assign w_in_fire  = i_s_tvalid && o_s_tready;
    assign w_out_fire = r_out_valid && i_m_tready;
    assign w_op       = t_op'(i_s_tuser);

    // Both differences wrap modulo 2^32. After the shift the oldest stamp is
    // the one that currently sits in the second-oldest cell.
    assign w_since = i_s_tdata - w_stamp[WINDOW-1];
    assign w_span  = i_s_tdata - w_stamp[1];

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_wait  = r_out_wait;
        n_out_rate  = r_out_rate;
        n_rate      = r_rate;
        w_ctrl      = '0;
        w_div_start = 1'b0;

        if (w_out_fire) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    unique case (w_op)
                        OP_START: begin
                            w_ctrl.fill = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_wait  = 1'b0;
                            n_out_rate  = r_rate;
                        end
                        OP_CHECK: begin
                            if (w_since < STAMP_W'(r_interval)) begin
                                n_out_valid = 1'b1;
                                n_out_wait  = 1'b1;
                                n_out_rate  = r_rate;
                            end else begin
                                w_ctrl.shift = 1'b1;
                                if (w_span == '0) begin
                                    // Zero span keeps the previous rate.
                                    n_out_valid = 1'b1;
                                    n_out_wait  = 1'b0;
                                    n_out_rate  = r_rate;
                                end else begin
                                    w_div_start = 1'b1;
                                    n_state     = ST_DIV;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // The result register is free here: it was empty or being taken
                // when the frame was accepted.
                if (w_div.done) begin
                    n_rate      = w_div.rate;
                    n_out_valid = 1'b1;
                    n_out_wait  = 1'b0;
                    n_out_rate  = w_div.rate;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rate      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rate      <= n_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_wait <= n_out_wait;
        r_out_rate <= n_out_rate;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_rate, r_out_wait};

    // No request may enter while a division is running.
    `ASSERT_CLKD(a_no_accept_in_div, (r_state == ST_DIV) |-> !o_s_tready, "request taken during division")
    // The divider only finishes while the controller waits for it.
    `ASSERT_CLKD(a_div_done_in_div, w_div.done |-> (r_state == ST_DIV), "division result with no frame pending")
    // An accepted frame leaves its time in the newest cell.
    `ASSERT_CLKD(a_newest_stamp, ($past(i_rst_n) && $past(w_ctrl.shift)) |-> (w_stamp[WINDOW-1] == $past(i_s_tdata)), "newest stamp not the frame time")
    // The start fill and the frame shift never happen together.
    `ASSERT_ALWAYS(a_ctrl_excl, !(w_ctrl.fill && w_ctrl.shift), "fill and shift at once")

endmodule

// ===== sim/frame_pacer_rate_meter_test.sv =====
module frame_pacer_rate_meter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fpr_pkg::*;

    // The run is cut off here. The slowest correct run is bounded by a sender
    // gap, the divider and a receiver stall for each request, plus one long
    // receiver hold-off.
    localparam int CYCLE_LIMIT   = 200000;
    // The quiet stretch at the end outlasts the divider, so it is
    // enough to catch any result that should not have been produced.
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int LONG_HOLD     = 300;

    // One result as the block should present it.
    typedef struct {
        logic              waiting;
        logic [RATE_W-1:0] rate;
    } t_reply;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [IVL_W-1:0]   i_cfg_wdata = '0;
    logic               i_s_tvalid  = 1'b0;
    logic               o_s_tready;
    logic [STAMP_W-1:0] i_s_tdata   = '0;   // [31:0] now_ms
    logic               i_s_tuser   = 1'b0; // [0] opcode
    logic               o_m_tvalid;
    logic               i_m_tready  = 1'b0;
    logic [OUT_W-1:0]   o_m_tdata;          // [0] wait_res, [14:1] frame_rate

    // Our own copy of the time stamp window, the rate and the interval.
    logic [STAMP_W-1:0] stamp_hist [WINDOW];
    logic [RATE_W-1:0]  rate_model;
    logic [IVL_W-1:0]   interval_model;
    t_reply             replies_due [$];

    // Idling on both sides is switched off for some stretches of the run.
    bit idling_on   = 1'b1;
    int sink_wait   = 0;
    int hold_left   = 0;
    int mismatches  = 0;
    int cycle_count = 0;

    frame_pacer_rate_meter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // State after reset: an empty window, no rate yet, the default interval.
    function automatic void clear_pacer();
        for (int k = 0; k < WINDOW; k++) begin
            stamp_hist[k] = '0;
        end
        rate_model     = '0;
        interval_model = IVL_RESET;
    endfunction

    // Applies one request to the local copy of the pacer and returns the
    // result it should produce. A start request refills the window and keeps
    // the rate. A check request that comes too soon leaves everything alone.
    // An accepted frame moves the window, recomputes the rate over the span
    // back to the oldest stamp (kept as it was when that span is zero) and
    // stores its time as the newest stamp. All differences wrap at 32 bits.
    function automatic t_reply pace_frame(input t_op op, input logic [STAMP_W-1:0] now);
        t_reply             rep;
        logic [STAMP_W-1:0] since;
        logic [STAMP_W-1:0] span;
        logic [STAMP_W-1:0] quot;
        rep.waiting = 1'b0;
        if (op == OP_START) begin
            for (int k = 0; k < WINDOW - 1; k++) begin
                stamp_hist[k] = now;
            end
            stamp_hist[WINDOW-1] = '0;
        end else begin
            since = now - stamp_hist[WINDOW-1];
            if (since < STAMP_W'(interval_model)) begin
                rep.waiting = 1'b1;
            end else begin
                for (int k = 0; k < WINDOW - 1; k++) begin
                    stamp_hist[k] = stamp_hist[k+1];
                end
                span = now - stamp_hist[0];
                if (span != '0) begin
                    quot = STAMP_W'(RATE_NUM) / span;
                    rate_model = (quot > STAMP_W'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
                end
                stamp_hist[WINDOW-1] = now;
            end
        end
        rep.rate = rate_model;
        return rep;
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] want_v,
                                            input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t ns: %s differs: expected %0d, got %0d", $realtime, what, want_v,
                     got_v);
        end
    endfunction

    // Offers one request after a random gap and waits until it is taken. The
    // valid stays high after the handshake; the next request or the next
    // pause lowers or reuses it at the following falling edge, so it is
    // never taken twice.
    task automatic send_request(input t_op op, input logic [STAMP_W-1:0] now);
        int gap;
        gap = idling_on ? $urandom_range(0, 16) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= now;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        replies_due.push_back(pace_frame(op, now));
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic wait_for_replies();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (replies_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The interval register is only written while the block has nothing in
    // flight, so the model can take the new value at once.
    task automatic write_interval(input logic [IVL_W-1:0] ivl);
        wait_for_replies();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ivl;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        interval_model = ivl;
    endtask

    // Default interval of 16 ms right after reset: a frame at 15 ms is too
    // soon, one at exactly 16 ms is taken.
    task automatic test_reset_interval();
        idling_on = 1'b1;
        send_request(OP_CHECK, 32'd0);
        send_request(OP_CHECK, 32'd15);
        send_request(OP_CHECK, 32'd16);
        send_request(OP_CHECK, 32'd31);
        send_request(OP_CHECK, 32'd32);
    endtask

    // Start requests, wait answers, a zero span, the largest rate, a time
    // that runs backward and times that wrap around zero.
    task automatic test_window_cases();
        send_request(OP_START, 32'd1000);
        send_request(OP_CHECK, 32'd1005);
        send_request(OP_CHECK, 32'd1010);
        send_request(OP_CHECK, 32'd1021);
        // A frame at the start time: the span is zero and the rate stays.
        send_request(OP_START, 32'd5000);
        send_request(OP_CHECK, 32'd5000);
        // A span of one millisecond gives the top rate.
        send_request(OP_START, 32'd100);
        send_request(OP_CHECK, 32'd101);
        // Going back to zero looks like a very long wait and a huge span.
        send_request(OP_CHECK, 32'd0);
        send_request(OP_START, 32'hFFFF_FFF0);
        send_request(OP_CHECK, 32'h0000_0010);
        send_request(OP_CHECK, 32'hFFFF_FFFF);
    endtask

    // The smallest interval accepts a frame at the same time as the last one;
    // the largest needs the full 65535 ms.
    task automatic test_interval_extremes();
        write_interval(16'd0);
        send_request(OP_START, 32'd200);
        send_request(OP_CHECK, 32'd200);
        send_request(OP_CHECK, 32'd200);
        write_interval(16'hFFFF);
        send_request(OP_CHECK, 32'd200 + 32'd65534);
        send_request(OP_CHECK, 32'd200 + 32'd65535);
        send_request(OP_CHECK, 32'hAAAA_5555);
        write_interval(IVL_RESET);
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block fills up and has to stall its request channel.
    task automatic test_result_backpressure();
        logic [STAMP_W-1:0] now;
        now = $urandom;
        hold_left = LONG_HOLD;
        send_request(OP_START, now);
        repeat (8) begin
            now = now + $urandom_range(0, 40);
            send_request(OP_CHECK, now);
        end
        wait_for_replies();
    endtask

    // The sender pauses until every result is back, then sends a burst with
    // no idling on either side.
    task automatic test_paused_sender();
        logic [STAMP_W-1:0] now;
        now = $urandom;
        send_request(OP_START, now);
        repeat (5) begin
            now = now + $urandom_range(10, 30);
            send_request(OP_CHECK, now);
        end
        wait_for_replies();
        idling_on = 1'b0;
        repeat (6) begin
            now = now + $urandom_range(0, 30);
            send_request(OP_CHECK, now);
        end
        wait_for_replies();
        idling_on = 1'b1;
    endtask

    // Random frame streams under several intervals. Most requests are checks
    // whose times step forward by about one interval, so the window fills with
    // real history and the rate moves; a few are fresh starts or checks at an
    // unrelated time.
    task automatic test_random_frames();
        logic [IVL_W-1:0]   ivl;
        logic [STAMP_W-1:0] now;
        int                 pick;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    ivl = IVL_RESET;
                end
                1: begin
                    ivl = 16'd0;
                end
                2: begin
                    ivl = 16'd1;
                end
                3: begin
                    ivl = IVL_W'($urandom_range(2, 1000));
                end
                4: begin
                    ivl = 16'hFFFF;
                end
                default: begin
                    ivl = IVL_W'($urandom_range(0, 65535));
                end
            endcase
            write_interval(ivl);
            idling_on = (phase != 2);
            now = $urandom;
            send_request(OP_START, now);
            repeat (66) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    now = $urandom;
                    send_request(OP_START, now);
                end else if (pick < 10) begin
                    send_request(OP_CHECK, $urandom);
                end else begin
                    if ($urandom_range(0, 99) < 30) begin
                        now = now + $urandom_range(0, ivl);
                    end else begin
                        now = now + $urandom_range(ivl, 2 * ivl + 8);
                    end
                    send_request(OP_CHECK, now);
                end
            end
        end
        idling_on = 1'b1;
    endtask

    // Result side: the ready is driven at the falling edge, low during the
    // long hold-off and during the stall drawn after each result.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Every result taken is compared with the oldest expectation, field by
    // field. The padding bit above the rate is not part of any field.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sink_wait = idling_on ? $urandom_range(0, 16) : 0;
            if (replies_due.size() == 0) begin
                report_mismatch("result with no request waiting", 32'd0, 32'(o_m_tdata));
            end else begin
                want = replies_due.pop_front();
                if (o_m_tdata[0] !== want.waiting) begin
                    report_mismatch("wait_res", 32'(want.waiting), 32'(o_m_tdata[0]));
                end
                if (o_m_tdata[RATE_W:1] !== want.rate) begin
                    report_mismatch("frame_rate", 32'(want.rate), 32'(o_m_tdata[RATE_W:1]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        clear_pacer();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_interval();
        test_window_cases();
        test_interval_extremes();
        test_result_backpressure();
        test_paused_sender();
        test_random_frames();

        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
